// File: rtl/core/ssfpl_pkg.sv
// shared constants and controller/datapath interface types for the sorted set lookup
package ssfpl_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 11;

  // request kinds carried in the request flag bit
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;      // latch the incoming word, start a search window
    logic rd_mid;      // read the midpoint of the search window
    logic cmp;         // narrow the window using the read data
    logic shift_init;  // point the shift index at the last held entry
    logic rd_shift;    // read the entry at the shift index
    logic wr_shift;    // write that entry one place up, step the index down
    logic store;       // write the key at the insert position, bump the count
    logic load_out;    // capture the query answer into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic full;
    logic search_done;
    logic no_shift;
    logic shift_last;
  } status_t;

endpackage

// File: rtl/core/ssfpl_dp.sv
// datapath: sorted value memory, search window, shift index and output register
module ssfpl_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ssfpl_pkg::cmd_t                    cmd_i,
  output ssfpl_pkg::status_t                 status_o,
  input  logic                               req_type_i,
  input  logic                               first_of_set_i,
  input  logic signed [ssfpl_pkg::VALUE_W-1:0] value_i,
  output logic                               found_o,
  output logic [ssfpl_pkg::POS_W-1:0]        position_o,
  output logic signed [ssfpl_pkg::VALUE_W-1:0] query_value_o
);

  logic signed [ssfpl_pkg::VALUE_W-1:0] mem [ssfpl_pkg::MAX_ENTRIES];
  logic signed [ssfpl_pkg::VALUE_W-1:0] rdata_q;
  logic signed [ssfpl_pkg::VALUE_W-1:0] key_q;
  logic                                 query_q;
  logic [ssfpl_pkg::CNT_W-1:0]          count_q, count_d;
  logic [ssfpl_pkg::CNT_W-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                                 eq_q, eq_d;
  logic [ssfpl_pkg::ADDR_W-1:0]         idx_q, idx_d;
  logic [ssfpl_pkg::CNT_W:0]            mid_sum;
  logic [ssfpl_pkg::CNT_W:0]            pos_inc;
  logic                                 go_right;
  logic                                 hit;

  logic                                 mem_we, mem_re;
  logic [ssfpl_pkg::ADDR_W-1:0]         mem_waddr, mem_raddr;
  logic signed [ssfpl_pkg::VALUE_W-1:0] mem_wdata;

  logic                                 found_q;
  logic [ssfpl_pkg::POS_W-1:0]          position_q;
  logic signed [ssfpl_pkg::VALUE_W-1:0] qval_q;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_d   = mid_sum[ssfpl_pkg::CNT_W:1];

  // queries look for the first entry not below the key, loads for the first above it
  assign go_right = query_q ? (rdata_q < key_q) : (rdata_q <= key_q);

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    eq_d    = eq_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.accept) begin
      lo_d = '0;
      eq_d = 1'b0;
      if (req_type_i == ssfpl_pkg::REQ_LOAD && first_of_set_i) begin
        count_d = '0;
        hi_d    = '0;
      end else begin
        hi_d = count_q;
      end
    end
    if (cmd_i.cmp) begin
      if (go_right) begin
        lo_d = mid_q + 1'b1;
      end else begin
        hi_d = mid_q;
        eq_d = (rdata_q == key_q);
      end
    end
    if (cmd_i.shift_init) begin
      idx_d = ssfpl_pkg::ADDR_W'(count_q - 1'b1);
    end
    if (cmd_i.wr_shift) begin
      idx_d = idx_q - 1'b1;
    end
    if (cmd_i.store) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    eq_q  <= eq_d;
    idx_q <= idx_d;
    if (cmd_i.rd_mid) begin
      mid_q <= mid_d;
    end
    if (cmd_i.accept) begin
      key_q   <= value_i;
      query_q <= req_type_i;
    end
  end

  // single write port, single read port with registered data
  assign mem_we    = cmd_i.wr_shift | cmd_i.store;
  assign mem_waddr = cmd_i.store ? lo_q[ssfpl_pkg::ADDR_W-1:0] : idx_q + 1'b1;
  assign mem_wdata = cmd_i.store ? key_q : rdata_q;
  assign mem_re    = cmd_i.rd_mid | cmd_i.rd_shift;
  assign mem_raddr = cmd_i.rd_mid ? mid_d[ssfpl_pkg::ADDR_W-1:0] : idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // final lo equals the last midpoint that moved hi, so eq_q covers the hit check
  assign hit     = (lo_q < count_q) && eq_q;
  assign pos_inc = {1'b0, lo_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_q    <= hit;
      position_q <= hit ? ssfpl_pkg::POS_W'(pos_inc) : '0;
      qval_q     <= key_q;
    end
  end

  assign found_o       = found_q;
  assign position_o    = position_q;
  assign query_value_o = qval_q;

  assign status_o.is_query    = query_q;
  assign status_o.full        = (count_q >= ssfpl_pkg::CNT_W'(ssfpl_pkg::MAX_ENTRIES));
  assign status_o.search_done = (lo_q >= hi_q);
  assign status_o.no_shift    = (lo_q == count_q);
  assign status_o.shift_last  = (ssfpl_pkg::CNT_W'(idx_q) == lo_q);

endmodule

// File: rtl/core/ssfpl_ctrl.sv
// controller: sequences search, insert shift, store and result hand-off
module ssfpl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  input  ssfpl_pkg::status_t status_i,
  output ssfpl_pkg::cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_CHECK    = 8'b0000_0010,
    ST_SEARCH   = 8'b0000_0100,
    ST_CMP      = 8'b0000_1000,
    ST_SHIFT_RD = 8'b0001_0000,
    ST_SHIFT_WR = 8'b0010_0000,
    ST_STORE    = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   m_tvalid_q, m_tvalid_d;
  logic   out_free;

  assign out_free = !m_tvalid_q || m_tready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    m_tvalid_d = m_tvalid_q && !m_tready_i;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status_i.is_query && status_i.full) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!status_i.search_done) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = ST_CMP;
        end else if (status_i.is_query) begin
          state_d = ST_DONE;
        end else if (status_i.no_shift) begin
          state_d = ST_STORE;
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT_RD;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_SEARCH;
      end
      ST_SHIFT_RD: begin
        cmd_o.rd_shift = 1'b1;
        state_d        = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = status_i.shift_last ? ST_STORE : ST_SHIFT_RD;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          m_tvalid_d     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  assign m_tvalid_o = m_tvalid_q;

endmodule

// File: rtl/core/sorted_set_first_position_lookup.sv
// top level of the sorted set first-position lookup
//
// input channel s_*: each word is a load or a query (s_tuser_i[0], 1 = query).
// a load with s_tuser_i[1] set empties the set first; a load into a full set
// (1024 entries) is dropped. loads give no output word.
// output channel m_*: one word per query with found in m_tuser_o and the
// 1-based position of the first equal entry (0 when absent) plus the echoed
// value in m_tdata_o.
// search: a query runs a binary search of at most k = ceil(log2(n+1))
// steps over n held entries before output valid; each step is one memory
// read plus one compare.
// a load takes the same search, then one read and one write per entry moved
// up to make room (single-port-pair memory), plus one store.
// one item is in work at a time; s_tready_o is high only while idle.
// the output register decouples the sides: a finished answer may wait while
// the next word is accepted; a second answer waits in the controller until
// the register drains, and no input word is taken while it waits.
// reset empties the set (count to zero) and clears output valid; memory
// contents are not cleared, they are only read below the count.
module sorted_set_first_position_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic [1:0]  s_tuser_i,   // [0] req_type, [1] first_of_set
  // result stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o,   // [10:0] position, [42:11] query_value, [47:43] zero
  output logic [0:0]  m_tuser_o    // [0] found
);

  ssfpl_pkg::cmd_t    cmd;
  ssfpl_pkg::status_t status;

  logic                                 found;
  logic [ssfpl_pkg::POS_W-1:0]          position;
  logic signed [ssfpl_pkg::VALUE_W-1:0] query_value;

  // sequencing only: handshakes and commands
  ssfpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // memory, search window, shifter and result register
  ssfpl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (s_tuser_i[0]),
    .first_of_set_i (s_tuser_i[1]),
    .value_i        ($signed(s_tdata_i)),
    .found_o        (found),
    .position_o     (position),
    .query_value_o  (query_value)
  );

  assign m_tdata_o = {5'b0, query_value, position};
  assign m_tuser_o = found;

endmodule
